// ===== hdl/tafm_pkg.sv =====
// ---------------------------------------------------------------------------
// tafm_pkg
// Shared types and constants for the throttle arming / flight mode controller.
// ---------------------------------------------------------------------------
package tafm_pkg;

  localparam int THR_W   = 10;
  localparam int HOLD_W  = 16;
  localparam int RETRY_W = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_AW  = 2;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_HIGH_THR = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LOW_THR  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_HOLD     = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_RETRY    = 2'd3;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0]   HIGH_THR_RST = 10'd900;
  localparam logic [THR_W-1:0]   LOW_THR_RST  = 10'd100;
  localparam logic [HOLD_W-1:0]  HOLD_RST     = 16'd1000;
  localparam logic [RETRY_W-1:0] RETRY_RST    = 8'd10;

  localparam logic [RETRY_W-1:0] FAIL_MAX = '1;

  // Reported codes
  localparam logic [1:0] MODE_CODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_CODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_CODE_HOLD   = 2'd2;
  localparam logic [1:0] MODE_CODE_FAULT  = 2'd3;

  localparam logic [2:0] PH_CODE_FREE   = 3'd0;
  localparam logic [2:0] PH_CODE_HIGH   = 3'd1;
  localparam logic [2:0] PH_CODE_LEFT   = 3'd2;
  localparam logic [2:0] PH_CODE_LOW    = 3'd3;
  localparam logic [2:0] PH_CODE_UNLOCK = 3'd4;

  typedef struct packed {
    logic [THR_W-1:0]   high_thr;
    logic [THR_W-1:0]   low_thr;
    logic [HOLD_W-1:0]  hold_ticks;
    logic [RETRY_W-1:0] retry_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    M_IDLE   = 4'b0001,
    M_NORMAL = 4'b0010,
    M_HOLD   = 4'b0100,
    M_FAULT  = 4'b1000
  } mode_t;

  typedef enum logic [4:0] {
    PH_FREE   = 5'b00001,
    PH_HIGH   = 5'b00010,
    PH_LEFT   = 5'b00100,
    PH_LOW    = 5'b01000,
    PH_UNLOCK = 5'b10000
  } phase_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    case (m)
      M_IDLE:   c = MODE_CODE_IDLE;
      M_NORMAL: c = MODE_CODE_NORMAL;
      M_HOLD:   c = MODE_CODE_HOLD;
      M_FAULT:  c = MODE_CODE_FAULT;
      default:  c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] phase_code(phase_t p);
    logic [2:0] c;
    case (p)
      PH_FREE:   c = PH_CODE_FREE;
      PH_HIGH:   c = PH_CODE_HIGH;
      PH_LEFT:   c = PH_CODE_LEFT;
      PH_LOW:    c = PH_CODE_LOW;
      PH_UNLOCK: c = PH_CODE_UNLOCK;
      default:   c = PH_CODE_FREE;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/throttle_arming_flight_mode_fsm_unit.sv =====
// ---------------------------------------------------------------------------
// throttle_arming_flight_mode_fsm_unit
// Per-tick link tracking, stick arming and flight mode control.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata: tick inputs
//  out_    | out | out_tvalid/tready  | out_tdata: mode, link, phase, height
//  cfg_    | in  | cfg_we             | cfg_addr, cfg_wdata
//
//  One word per cycle sustained while out_tready holds high; out_tvalid rises
//  once the word has passed the input register and the state registers that
//  feed out_tdata have been loaded from it.
//  The state update for a word happens when it moves from the input register
//  into the output slot, so a stalled output holds state and input in place.
//  Reset (rst_n low, synchronous) clears state and loads register defaults.
module throttle_arming_flight_mode_fsm_unit #(
  parameter int TIME_WIDTH   = 32,
  parameter int HEIGHT_WIDTH = 16,
  localparam int IN_BITS     = 13 + HEIGHT_WIDTH + TIME_WIDTH,
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS    = 6 + HEIGHT_WIDTH,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // link_ok, throttle[10], hold_request, height_mm, now_ticks, fault_clear
  input  logic [IN_TDATA_W-1:0]         in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // flight_mode[2], link_up, arm_phase[3], hold_height
  output logic [OUT_TDATA_W-1:0]        out_tdata,
  input  logic                          cfg_we,
  input  logic [tafm_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [tafm_pkg::CFG_W-1:0]    cfg_wdata
);
  import tafm_pkg::*;

  localparam int THR_LSB    = 1;
  localparam int HOLD_BIT   = THR_LSB + THR_W;
  localparam int HEIGHT_LSB = HOLD_BIT + 1;
  localparam int NOW_LSB    = HEIGHT_LSB + HEIGHT_WIDTH;
  localparam int CLR_BIT    = NOW_LSB + TIME_WIDTH;

  cfg_t cfg_r;

  logic                    in_vld_r;
  logic                    in_link_ok_r;
  logic [THR_W-1:0]        in_thr_r;
  logic                    in_hold_r;
  logic [HEIGHT_WIDTH-1:0] in_height_r;
  logic [TIME_WIDTH-1:0]   in_now_r;
  logic                    in_clr_r;

  logic                    out_vld_r;
  logic                    adv;
  logic                    in_acc;

  mode_t                   mode_r;
  mode_t                   mode_nxt;
  logic [HEIGHT_WIDTH-1:0] target_r;
  logic [HEIGHT_WIDTH-1:0] target_nxt;
  logic                    link_nxt;
  logic                    link_r;
  phase_t                  phase_r;
  logic                    arm_done;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_thr    <= HIGH_THR_RST;
      cfg_r.low_thr     <= LOW_THR_RST;
      cfg_r.hold_ticks  <= HOLD_RST;
      cfg_r.retry_limit <= RETRY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HIGH_THR: cfg_r.high_thr    <= cfg_wdata[THR_W-1:0];
        CFG_LOW_THR:  cfg_r.low_thr     <= cfg_wdata[THR_W-1:0];
        CFG_HOLD:     cfg_r.hold_ticks  <= cfg_wdata[HOLD_W-1:0];
        CFG_RETRY:    cfg_r.retry_limit <= cfg_wdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: word moves on when the output slot is free or being drained
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_link_ok_r <= in_tdata[0];
      in_thr_r     <= in_tdata[HOLD_BIT-1:THR_LSB];
      in_hold_r    <= in_tdata[HOLD_BIT];
      in_height_r  <= in_tdata[NOW_LSB-1:HEIGHT_LSB];
      in_now_r     <= in_tdata[CLR_BIT-1:NOW_LSB];
      in_clr_r     <= in_tdata[CLR_BIT];
    end
  end

  // Link tracking runs first in each tick
  tafm_link u_link (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .link_ok     (in_link_ok_r),
    .retry_limit (cfg_r.retry_limit),
    .link_nxt    (link_nxt),
    .link_r      (link_r)
  );

  // Arming sequence only steps while idle
  tafm_arm #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_arm (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv && (mode_r == M_IDLE)),
    .thr     (in_thr_r),
    .now     (in_now_r),
    .cfg     (cfg_r),
    .phase_r (phase_r),
    .done    (arm_done)
  );

  // Flight mode
  always_comb begin
    mode_nxt   = mode_r;
    target_nxt = target_r;
    case (mode_r)
      M_IDLE: begin
        if (arm_done) begin
          mode_nxt = M_NORMAL;
        end
      end
      M_NORMAL: begin
        if (in_hold_r) begin
          mode_nxt   = M_HOLD;
          target_nxt = in_height_r;
        end
        if (!link_nxt) begin
          mode_nxt = M_FAULT;
        end
      end
      M_HOLD: begin
        if (in_hold_r) begin
          mode_nxt = M_NORMAL;
        end
        if (!link_nxt) begin
          mode_nxt = M_FAULT;
        end
      end
      M_FAULT: begin
        if (in_clr_r) begin
          mode_nxt = M_IDLE;
        end
      end
      default: mode_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      target_r <= '0;
    end else if (adv) begin
      mode_r   <= mode_nxt;
      target_r <= target_nxt;
    end
  end

  // Output slot; payload is the state itself, frozen while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'({target_r, phase_code(phase_r), link_r,
                                    mode_code(mode_r)});

`ifndef SYNTHESIS
  // Fault is left only toward idle
  a_fault_exit: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(mode_r == M_FAULT) && (mode_r != M_FAULT)
      |-> (mode_r == M_IDLE))
    else $error("fault mode left to a mode other than idle");

  // Arming phase only moves while idle
  a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (phase_r != $past(phase_r)) |-> $past(mode_r == M_IDLE))
    else $error("arming phase changed outside idle");

  // Link comes up only on a good reception
  a_link_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(link_r) |-> $past(adv && in_link_ok_r))
    else $error("link came up without a good reception");

  // State changes only when a word moves into the output slot
  a_state_adv: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(adv) |-> $stable(mode_r) && $stable(target_r))
    else $error("mode state changed without an advancing word");
`endif

endmodule

// ===== hdl/tafm_link.sv =====
// ---------------------------------------------------------------------------
// tafm_link
// Link tracker: consecutive failure counter and connected flag.
// ---------------------------------------------------------------------------
module tafm_link (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    link_ok,
  input  logic [tafm_pkg::RETRY_W-1:0] retry_limit,
  output logic                    link_nxt,
  output logic                    link_r
);
  import tafm_pkg::*;

  logic [RETRY_W-1:0] fail_cnt_r;
  logic [RETRY_W-1:0] fail_cnt_nxt;

  // Saturating failure count, link drops once the count reaches the limit
  always_comb begin
    fail_cnt_nxt = fail_cnt_r;
    link_nxt     = link_r;
    if (link_ok) begin
      fail_cnt_nxt = '0;
      link_nxt     = 1'b1;
    end else begin
      if (fail_cnt_r != FAIL_MAX) begin
        fail_cnt_nxt = fail_cnt_r + RETRY_W'(1);
      end
      if (fail_cnt_nxt >= retry_limit) begin
        link_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_cnt_r <= '0;
      link_r     <= 1'b0;
    end else if (adv) begin
      fail_cnt_r <= fail_cnt_nxt;
      link_r     <= link_nxt;
    end
  end

endmodule

// ===== hdl/tafm_arm.sv =====
// ---------------------------------------------------------------------------
// tafm_arm
// Throttle stick arming sequencer: high, left high, low, unlocked.
// ---------------------------------------------------------------------------
module tafm_arm #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [tafm_pkg::THR_W-1:0]  thr,
  input  logic [TIME_WIDTH-1:0]       now,
  input  tafm_pkg::cfg_t              cfg,
  output tafm_pkg::phase_t            phase_r,
  output logic                        done
);
  import tafm_pkg::*;

  phase_t                phase_nxt;
  logic [TIME_WIDTH-1:0] high_since_r;
  logic [TIME_WIDTH-1:0] high_since_nxt;
  logic [TIME_WIDTH-1:0] low_since_r;
  logic [TIME_WIDTH-1:0] low_since_nxt;
  logic                  is_high;
  logic                  is_low;
  logic                  high_done;
  logic                  low_done;

  assign is_high = thr >= cfg.high_thr;
  assign is_low  = thr <= cfg.low_thr;

  // Wrapping dwell checks
  assign high_done = (now - high_since_r) >= TIME_WIDTH'(cfg.hold_ticks);
  assign low_done  = (now - low_since_r)  >= TIME_WIDTH'(cfg.hold_ticks);

  assign done = (phase_r == PH_UNLOCK);

  always_comb begin
    phase_nxt      = phase_r;
    high_since_nxt = high_since_r;
    low_since_nxt  = low_since_r;
    case (phase_r)
      PH_FREE: begin
        if (is_high) begin
          phase_nxt      = PH_HIGH;
          high_since_nxt = now;
        end
      end
      PH_HIGH: begin
        if (!is_high) begin
          phase_nxt = high_done ? PH_LEFT : PH_FREE;
        end
      end
      PH_LEFT: begin
        if (is_low) begin
          phase_nxt     = PH_LOW;
          low_since_nxt = now;
        end
      end
      PH_LOW: begin
        // stick above low after the dwell: stay here until low again
        if (!is_low && !low_done) begin
          phase_nxt = PH_FREE;
        end else if (is_low && low_done) begin
          phase_nxt = PH_UNLOCK;
        end
      end
      PH_UNLOCK: phase_nxt = PH_FREE;
      default:   phase_nxt = PH_FREE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FREE;
      high_since_r <= '0;
      low_since_r  <= '0;
    end else if (en) begin
      phase_r      <= phase_nxt;
      high_since_r <= high_since_nxt;
      low_since_r  <= low_since_nxt;
    end
  end

endmodule
